[hw/rtl/signed_integer_to_ascii_assert.svh]
// ---------------------------------------------------------------------------
// Signed integer to ASCII - assertion macros
// Concurrent assertion wrappers on clk / rst_n; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_ASCII_ASSERT_SVH
`define SIGNED_INTEGER_TO_ASCII_ASSERT_SVH

`ifndef SYNTH
`define SIA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sia: same-cycle check failed");
`define SIA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sia: next-cycle check failed");
`else
`define SIA_ASSERT_IMP(lbl, ante, cons)
`define SIA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/sia_pkg.sv]
// ---------------------------------------------------------------------------
// Signed integer to ASCII - package
// Sizes, character codes, sequencer states and the radix reciprocal table.
// ---------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int RADIX_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 6;

    // q0 = (m * floor(2^S / d)) >> S is q or q-1 for S = W + 3
    localparam int RECIP_SHIFT = VALUE_WIDTH + 3;
    localparam int RECIP_W     = VALUE_WIDTH + 3;
    localparam int PROD_W      = VALUE_WIDTH + RECIP_W;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [RECIP_W-1:0]     recip_t;
    typedef logic [RADIX_W-1:0]     radix_t;
    typedef logic [CHAR_W-1:0]      char_t;
    typedef logic [LEN_W-1:0]       len_t;

    localparam radix_t RADIX_RESET = radix_t'(10);
    localparam radix_t RADIX_MIN   = radix_t'(2);
    localparam radix_t RADIX_MAX   = radix_t'(10);

    localparam char_t CHAR_ZERO  = char_t'(8'h30);
    localparam char_t CHAR_NINE  = char_t'(8'h39);
    localparam char_t CHAR_MINUS = char_t'(8'h2d);
    localparam char_t CHAR_NUL   = char_t'(8'h00);

    localparam logic [RECIP_SHIFT:0] ONE_SHIFTED = {1'b1, {RECIP_SHIFT{1'b0}}};
    localparam recip_t RECIP_2  = recip_t'(ONE_SHIFTED / 2);
    localparam recip_t RECIP_3  = recip_t'(ONE_SHIFTED / 3);
    localparam recip_t RECIP_4  = recip_t'(ONE_SHIFTED / 4);
    localparam recip_t RECIP_5  = recip_t'(ONE_SHIFTED / 5);
    localparam recip_t RECIP_6  = recip_t'(ONE_SHIFTED / 6);
    localparam recip_t RECIP_7  = recip_t'(ONE_SHIFTED / 7);
    localparam recip_t RECIP_8  = recip_t'(ONE_SHIFTED / 8);
    localparam recip_t RECIP_9  = recip_t'(ONE_SHIFTED / 9);
    localparam recip_t RECIP_10 = recip_t'(ONE_SHIFTED / 10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_SIGN,
        ST_DIGIT,
        ST_TERM
    } sia_state_t;

    function automatic radix_t effective_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    function automatic recip_t recip_of(input radix_t d);
        recip_t res;
        unique case (d)
            radix_t'(2):  res = RECIP_2;
            radix_t'(3):  res = RECIP_3;
            radix_t'(4):  res = RECIP_4;
            radix_t'(5):  res = RECIP_5;
            radix_t'(6):  res = RECIP_6;
            radix_t'(7):  res = RECIP_7;
            radix_t'(8):  res = RECIP_8;
            radix_t'(9):  res = RECIP_9;
            default:      res = RECIP_10;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/signed_integer_to_ascii.sv]
// ---------------------------------------------------------------------------
// Signed integer to ASCII
// Converts a signed value to its text in base 2..10, one byte per strobe.
// ---------------------------------------------------------------------------
//  channel   ports                                 handshake
//  input     value                                 start & !busy
//  output    char_byte, is_last, total_length      strobe, one cycle, no stall
//  config    radix                                 radix_wr_en
//
//  One shared reciprocal multiplier extracts each digit in a multiply state,
//  then a remainder fix-up state; once all digits are found, one byte is
//  emitted per cycle. The last byte leaves the output register in the same
//  cycle that busy drops.
//  Reset clears the sequencer and sets radix to 10; there is no clearing pass.
//  Output bytes cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_ascii
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire sia_pkg::value_t       value,
    input  wire logic                  radix_wr_en,
    input  wire sia_pkg::radix_t       radix,
    output      logic                  strobe,
    output      sia_pkg::char_t        char_byte,
    output      logic                  is_last,
    output      sia_pkg::len_t         total_length
);

    import sia_pkg::*;

    sia_state_t state_reg, state_next;

    radix_t                 radix_reg;
    radix_t                 base_reg,  base_next;
    value_t                 mag_reg,   mag_next;
    value_t                 q0_reg,    q0_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   neg_reg,   neg_next;
    len_t                   len_reg,   len_next;

    logic [RADIX_W-1:0]     digit_store [MAX_DIGITS];
    logic [RADIX_W-1:0]     rd_digit_reg;

    logic                   strobe_reg;
    char_t                  char_reg;
    logic                   last_reg;
    len_t                   total_reg;

    logic                   emit_valid;
    char_t                  emit_char;
    logic                   emit_last;
    len_t                   emit_len;

    logic                   accept;
    logic [PROD_W-1:0]      prod;
    logic [VALUE_WIDTH+RADIX_W-1:0] qd;
    value_t                 rem_raw;
    value_t                 rem_fix;
    value_t                 twice_base;
    logic                   fix;
    value_t                 quot;
    logic [RADIX_W-1:0]     digit;
    logic                   more;
    logic                   char_ok;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // shared divide-by-radix unit
    assign prod       = mag_reg * recip_of(base_reg);
    assign qd         = q0_reg * base_reg;
    assign rem_raw    = mag_reg - qd[VALUE_WIDTH-1:0];
    assign twice_base = VALUE_WIDTH'({base_reg, 1'b0});
    assign fix        = (rem_raw >= VALUE_WIDTH'(base_reg));
    assign rem_fix    = fix ? (rem_raw - VALUE_WIDTH'(base_reg)) : rem_raw;
    assign digit      = rem_fix[RADIX_W-1:0];
    assign quot       = q0_reg + VALUE_WIDTH'(fix);
    assign more       = (quot != '0) && ((count_reg + 1'b1) < CNT_W'(MAX_DIGITS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (more)
                begin
                    state_next = ST_MUL;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (rd_idx_reg == '0)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit_valid = 1'b0;
        emit_char  = CHAR_NUL;
        emit_last  = 1'b0;
        emit_len   = '0;
        unique case (state_reg)
            ST_SIGN:
            begin
                emit_valid = 1'b1;
                emit_char  = CHAR_MINUS;
            end
            ST_DIGIT:
            begin
                emit_valid = 1'b1;
                emit_char  = CHAR_ZERO + char_t'(rd_digit_reg);
            end
            ST_TERM:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                emit_len   = len_reg + 1'b1;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        base_next   = base_reg;
        mag_next    = mag_reg;
        q0_next     = q0_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        neg_next    = neg_reg;
        len_next    = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next  = effective_radix(radix_reg);
                    neg_next   = value[VALUE_WIDTH-1];
                    mag_next   = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
                    count_next = '0;
                    len_next   = '0;
                end
            end
            ST_MUL:
            begin
                q0_next = prod[PROD_W-1:RECIP_SHIFT];
            end
            ST_FIX:
            begin
                mag_next    = quot;
                count_next  = count_reg + 1'b1;
                rd_idx_next = count_reg[IDX_W-1:0];
            end
            ST_SIGN:
            begin
                len_next = len_reg + 1'b1;
            end
            ST_DIGIT:
            begin
                len_next = len_reg + 1'b1;
                if (rd_idx_reg != '0)
                begin
                    rd_idx_next = rd_idx_reg - 1'b1;
                end
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            radix_reg  <= RADIX_RESET;
            mag_reg    <= '0;
            count_reg  <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mag_reg    <= mag_next;
            count_reg  <= count_next;
            neg_reg    <= neg_next;
            strobe_reg <= emit_valid;
            if (radix_wr_en)
            begin
                radix_reg <= radix;
            end
        end
    end

    // read data follows rd_idx_reg; the digit written last is forwarded
    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        q0_reg     <= q0_next;
        rd_idx_reg <= rd_idx_next;
        len_reg    <= len_next;
        char_reg   <= emit_char;
        last_reg   <= emit_last;
        total_reg  <= emit_len;
        if (state_reg == ST_FIX)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= digit;
            rd_digit_reg                      <= digit;
        end
        else
        begin
            rd_digit_reg <= digit_store[rd_idx_next];
        end
    end

    assign strobe       = strobe_reg;
    assign char_byte    = char_reg;
    assign is_last      = strobe_reg && last_reg;
    assign total_length = strobe_reg ? total_reg : '0;

    assign char_ok = (char_byte == CHAR_MINUS) ||
                     ((char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE));

`include "signed_integer_to_ascii_assert.svh"

    `SIA_ASSERT_NXT(a_accept_busy, accept, busy)
    `SIA_ASSERT_IMP(a_fix_bound, state_reg == ST_FIX, rem_raw < twice_base)
    `SIA_ASSERT_IMP(a_last_strobe, is_last, strobe)
    `SIA_ASSERT_IMP(a_len_only_last, strobe && !is_last, total_length == '0)
    `SIA_ASSERT_IMP(a_char_code, strobe && !is_last, char_ok)

endmodule

`default_nettype wire

[tb/sv/tb_signed_integer_to_ascii.sv]
// ---------------------------------------------------------------------------
// Signed integer to ASCII - testbench
// Drives values in bursts with random gaps over a range of radix settings,
// predicts the byte run of every accepted value and checks each strobed
// byte in order against it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_signed_integer_to_ascii;

    import sia_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASE_ITEMS = 44;
    localparam int PHASES      = 8;

    typedef struct {
        char_t ch;
        logic  last;
        len_t  len;
    } text_byte_t;

    class text_scoreboard;
        radix_t     radix_reg;
        text_byte_t expected_text[$];
        int         errors;

        function new();
            radix_reg = RADIX_RESET;
            errors    = 0;
        endfunction

        // expand one accepted value into its expected byte run
        function void note_value(value_t v);
            radix_t     base;
            logic       neg;
            value_t     mag;
            logic [3:0] digits [MAX_DIGITS];
            int         cnt;
            int         k;
            text_byte_t b;
            base = radix_reg;
            if (base < RADIX_MIN)
            begin
                base = RADIX_MIN;
            end
            else if (base > RADIX_MAX)
            begin
                base = RADIX_MAX;
            end
            neg = v[VALUE_WIDTH-1];
            mag = neg ? (~v + value_t'(1)) : v;
            cnt = 0;
            do
            begin
                digits[cnt] = 4'(mag % base);
                mag         = mag / base;
                cnt++;
            end
            while (mag != 0 && cnt < MAX_DIGITS);
            k = 0;
            if (neg)
            begin
                b = '{CHAR_MINUS, 1'b0, len_t'(0)};
                expected_text.push_back(b);
                k++;
            end
            for (int i = cnt - 1; i >= 0; i--)
            begin
                b = '{char_t'(CHAR_ZERO + digits[i]), 1'b0, len_t'(0)};
                expected_text.push_back(b);
                k++;
            end
            b = '{CHAR_NUL, 1'b1, len_t'(k + 1)};
            expected_text.push_back(b);
        endfunction

        function void check_char(char_t ch, logic last, len_t len);
            text_byte_t e;
            if (expected_text.size() == 0)
            begin
                $display("%0t unexpected byte: expected none, actual char %h last %b len %0d",
                         $time, ch, last, len);
                errors++;
                return;
            end
            e = expected_text.pop_front();
            if (ch !== e.ch)
            begin
                $display("%0t char_byte: expected %h, actual %h", $time, e.ch, ch);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t is_last: expected %b, actual %b", $time, e.last, last);
                errors++;
            end
            if (len !== e.len)
            begin
                $display("%0t total_length: expected %0d, actual %0d", $time, e.len, len);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   start       = 1'b0;
    value_t value       = '0;
    logic   radix_wr_en = 1'b0;
    radix_t radix       = RADIX_RESET;
    logic   busy;
    logic   strobe;
    char_t  char_byte;
    logic   is_last;
    len_t   total_length;

    text_scoreboard sb = new();
    int             quiet_cycles = 0;

    signed_integer_to_ascii u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .radix_wr_en  (radix_wr_en),
        .radix        (radix),
        .strobe       (strobe),
        .char_byte    (char_byte),
        .is_last      (is_last),
        .total_length (total_length)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_value(value);
        end
        if (rst_n && strobe)
        begin
            sb.check_char(char_byte, is_last, total_length);
        end
        if (!rst_n || (start && !busy) || strobe)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[signed_integer_to_ascii] ERROR");
        $finish;
    end

    // holds start high until the item is taken; call right after posedge clk
    task automatic send_value(value_t v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_radix(radix_t r);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        radix_wr_en <= 1'b1;
        radix       <= r;
        @(posedge clk);
        radix_wr_en <= 1'b0;
        sb.radix_reg = r;
    endtask

    function automatic value_t pick_value(radix_t r);
        logic [63:0] p;
        int          base;
        value_t      v;
        base = (r < RADIX_MIN) ? 2 : ((r > RADIX_MAX) ? 10 : int'(r));
        case ($urandom_range(0, 7))
            0, 1:
            begin
                v = value_t'($urandom());
            end
            2:
            begin
                v = value_t'($urandom_range(0, 99));
            end
            3:
            begin
                v = -value_t'($urandom_range(1, 99));
            end
            4:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 31)) p = p * base;
                v = value_t'(p) + value_t'($urandom_range(0, 2)) - value_t'(1);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            5:
            begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default:
            begin
                v = value_t'($urandom()) >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_random(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && sent < n; b++)
            begin
                send_value(pick_value(sb.radix_reg));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                if ($urandom_range(0, 5) == 0)
                begin
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end
                else
                begin
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radix, extremes and sign handling
        send_value(value_t'(0));
        send_value(value_t'(1));
        send_value('1);
        send_value({1'b0, {(VALUE_WIDTH-1){1'b1}}});
        send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
        send_value(-value_t'(10));
        send_value(value_t'(9));

        write_radix(RADIX_MIN);
        send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
        send_value({1'b0, {(VALUE_WIDTH-1){1'b1}}});
        send_value(value_t'(0));
        send_value('1);
        send_value(value_t'(6));

        // radix below two falls back to two
        write_radix(radix_t'(0));
        send_value(value_t'(5));
        send_value(-value_t'(5));
        write_radix(radix_t'(1));
        send_value(value_t'(3));

        // radix above ten falls back to ten
        write_radix('1);
        send_value(-value_t'(123));
        send_value(value_t'(255));
        write_radix(radix_t'(11));
        send_value(value_t'(100));

        write_radix(radix_t'(3));
        send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
        write_radix(radix_t'(7));
        send_value(value_t'(48));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
            begin
                write_radix(RADIX_MAX);
            end
            else if (ph == PHASES - 1)
            begin
                write_radix(RADIX_MIN);
            end
            else if ($urandom_range(0, 1))
            begin
                write_radix(radix_t'($urandom_range(2, 10)));
            end
            else
            begin
                write_radix(radix_t'($urandom_range(0, 15)));
            end
            send_random(PHASE_ITEMS);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("[signed_integer_to_ascii] OK");
        end
        else
        begin
            $display("[signed_integer_to_ascii] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
